### src/mmt_pkg.sv
// Package for the multiset mex tracker: controller state encoding and status codes.
// No dependencies; used by mex_multiset_tracker_top.
package mmt_pkg;

	typedef enum logic [5:0] {
		S_CLR  = 6'b000001,
		S_IDLE = 6'b000010,
		S_RD   = 6'b000100,
		S_MOD  = 6'b001000,
		S_SRCH = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	typedef logic [1:0] status_t;

	localparam status_t STAT_OK     = 2'd0;
	localparam status_t STAT_ABSENT = 2'd1;
	localparam status_t STAT_SAT    = 2'd2;

endpackage

### src/mmt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/mex_multiset_tracker_top.sv
// Multiset mex tracker: per-value counts in one RAM, per-block presence rows in another.
// The result strobe (done) is high in S_OUT, after S_RD, S_MOD and S_SRCH; a new word can be
// accepted in the cycle that shows the result, and busy holds off new words during the
// read / modify / search / row-read sequence over the two RAMs. The receiver cannot stall.
// Reset: after arst_n releases, a clearing sweep of VALUE_LIMIT cycles zeroes both RAMs;
// busy stays high through it.
module mex_multiset_tracker_top #(
	parameter int VALUE_LIMIT = 1024,
	parameter int BLOCK_SIZE  = 32,
	parameter int COUNT_BITS  = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               req_type,
	input  logic [15:0]                        value,
	output logic                               done,
	output logic [$clog2(VALUE_LIMIT+1)-1:0]   mex,
	output logic [1:0]                         status
);

	localparam int NBLOCKS   = (VALUE_LIMIT + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int CW        = $clog2(VALUE_LIMIT);
	localparam int BKW       = (NBLOCKS > 1) ? $clog2(NBLOCKS) : 1;
	localparam int OW        = $clog2(BLOCK_SIZE);
	localparam int MXW       = $clog2(VALUE_LIMIT + 1);
	localparam int LAST_SPAN = VALUE_LIMIT - (NBLOCKS - 1) * BLOCK_SIZE;
	// reciprocal for value / BLOCK_SIZE, exact over all 16-bit values
	localparam int SH        = 16 + OW;
	localparam longint unsigned RECIP = ((64'd1 << SH) + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int RW        = 18;
	localparam int PW        = 16 + RW;

	mmt_pkg::state_t state_q;

	logic [CW-1:0]          clr_cnt_q;
	logic [NBLOCKS-1:0]     full_q;
	logic                   req_q;
	logic [15:0]            value_q;
	logic                   tracked_q;
	logic [BKW-1:0]         blk_q;
	logic [OW-1:0]          off_q;
	mmt_pkg::status_t       status_q;
	logic [BKW-1:0]         sel_q;
	logic                   none_q;

	logic                   accept;
	logic [PW-1:0]          prod;
	logic [PW-SH-1:0]       quo;
	logic [16:0]            base_v;
	logic [16:0]            off_full;

	logic                   cnt_we;
	logic [CW-1:0]          cnt_waddr;
	logic [COUNT_BITS-1:0]  cnt_wdata;
	logic [COUNT_BITS-1:0]  cnt_rdata;
	logic                   prs_we;
	logic [BKW-1:0]         prs_waddr;
	logic [BLOCK_SIZE-1:0]  prs_wdata;
	logic [BKW-1:0]         prs_raddr;
	logic [BLOCK_SIZE-1:0]  prs_rdata;

	logic [BLOCK_SIZE-1:0]  last_pad;
	logic [BLOCK_SIZE-1:0]  pad_mod;
	logic [BLOCK_SIZE-1:0]  pad_out;
	logic [COUNT_BITS-1:0]  new_cnt;
	logic [BLOCK_SIZE-1:0]  new_row;
	logic                   upd;
	mmt_pkg::status_t       stat_nx;
	logic                   blk_found;
	logic [BKW-1:0]         blk_sel;
	logic [OW-1:0]          zero_idx;
	logic [16:0]            mex_full;

	assign accept = start && !busy;
	assign busy   = !(state_q == mmt_pkg::S_IDLE || state_q == mmt_pkg::S_OUT);

	assign prod = PW'(value) * PW'(RECIP);
	assign quo  = prod[PW-1:SH];

	assign base_v   = 17'(blk_q) * 17'(BLOCK_SIZE);
	assign off_full = {1'b0, value_q} - base_v;

	// offsets past the end of a short last block count as present
	for (genvar g = 0; g < BLOCK_SIZE; g++) begin : g_pad
		assign last_pad[g] = (g >= LAST_SPAN);
	end

	assign pad_mod = (blk_q == BKW'(NBLOCKS - 1)) ? last_pad : '0;
	assign pad_out = (sel_q == BKW'(NBLOCKS - 1)) ? last_pad : '0;

	// update of the count and the presence row
	always_comb begin
		new_cnt = cnt_rdata;
		new_row = prs_rdata;
		upd     = 1'b0;
		stat_nx = mmt_pkg::STAT_OK;
		if (tracked_q) begin
			if (req_q) begin
				if (cnt_rdata == '0) begin
					stat_nx = mmt_pkg::STAT_ABSENT;
				end else begin
					upd     = 1'b1;
					new_cnt = cnt_rdata - COUNT_BITS'(1);
					if (new_cnt == '0) begin
						new_row[off_q] = 1'b0;
					end
				end
			end else begin
				if (cnt_rdata == '1) begin
					stat_nx = mmt_pkg::STAT_SAT;
				end else begin
					upd            = 1'b1;
					new_cnt        = cnt_rdata + COUNT_BITS'(1);
					new_row[off_q] = 1'b1;
				end
			end
		end
	end

	// lowest block that is not full
	always_comb begin
		blk_found = 1'b0;
		blk_sel   = '0;
		for (int i = NBLOCKS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				blk_found = 1'b1;
				blk_sel   = BKW'(i);
			end
		end
	end

	// lowest absent value inside the selected row
	always_comb begin
		zero_idx = '0;
		for (int i = BLOCK_SIZE - 1; i >= 0; i--) begin
			if (!(prs_rdata[i] | pad_out[i])) begin
				zero_idx = OW'(i);
			end
		end
	end

	assign mex_full = 17'(sel_q) * 17'(BLOCK_SIZE) + 17'(zero_idx);
	assign mex      = none_q ? MXW'(VALUE_LIMIT) : mex_full[MXW-1:0];
	assign status   = status_q;
	assign done     = (state_q == mmt_pkg::S_OUT);

	// RAM port muxing
	always_comb begin
		if (state_q == mmt_pkg::S_CLR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_cnt_q;
			cnt_wdata = '0;
			prs_we    = (32'(clr_cnt_q) < NBLOCKS);
			prs_waddr = clr_cnt_q[BKW-1:0];
			prs_wdata = '0;
		end else begin
			cnt_we    = (state_q == mmt_pkg::S_MOD) && upd;
			cnt_waddr = value_q[CW-1:0];
			cnt_wdata = new_cnt;
			prs_we    = (state_q == mmt_pkg::S_MOD) && upd;
			prs_waddr = blk_q;
			prs_wdata = new_row;
		end
	end

	assign prs_raddr = (state_q == mmt_pkg::S_SRCH) ? blk_sel : blk_q;

	mmt_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (VALUE_LIMIT)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (value_q[CW-1:0]),
		.rdata (cnt_rdata)
	);

	mmt_ram #(
		.WIDTH (BLOCK_SIZE),
		.DEPTH (NBLOCKS)
	) u_prs_ram (
		.clk   (clk),
		.we    (prs_we),
		.waddr (prs_waddr),
		.wdata (prs_wdata),
		.raddr (prs_raddr),
		.rdata (prs_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= mmt_pkg::S_CLR;
			clr_cnt_q <= '0;
			full_q    <= '0;
		end else begin
			case (state_q)
				mmt_pkg::S_CLR: begin
					clr_cnt_q <= clr_cnt_q + CW'(1);
					if (clr_cnt_q == CW'(VALUE_LIMIT - 1)) begin
						state_q <= mmt_pkg::S_IDLE;
					end
				end
				mmt_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= mmt_pkg::S_RD;
					end
				end
				mmt_pkg::S_RD: begin
					state_q <= mmt_pkg::S_MOD;
				end
				mmt_pkg::S_MOD: begin
					if (upd) begin
						full_q[blk_q] <= &(new_row | pad_mod);
					end
					state_q <= mmt_pkg::S_SRCH;
				end
				mmt_pkg::S_SRCH: begin
					state_q <= mmt_pkg::S_OUT;
				end
				mmt_pkg::S_OUT: begin
					state_q <= accept ? mmt_pkg::S_RD : mmt_pkg::S_IDLE;
				end
				default: begin
					state_q <= mmt_pkg::S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_type;
			value_q   <= value;
			tracked_q <= ({1'b0, value} < 17'(VALUE_LIMIT));
			blk_q     <= quo[BKW-1:0];
		end
		if (state_q == mmt_pkg::S_RD) begin
			off_q <= off_full[OW-1:0];
		end
		if (state_q == mmt_pkg::S_MOD) begin
			status_q <= stat_nx;
		end
		if (state_q == mmt_pkg::S_SRCH) begin
			sel_q  <= blk_sel;
			none_q <= !blk_found;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##4 done)
		else $error("result strobe not three cycles after the read cycle");

	a_mex_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(mex) <= VALUE_LIMIT))
		else $error("mex beyond the tracked limit");

	a_no_write_untracked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmt_pkg::S_MOD && cnt_we) |-> tracked_q)
		else $error("count write for an untracked value");

	a_flagged_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mmt_pkg::S_MOD && stat_nx != mmt_pkg::STAT_OK) |-> (!cnt_we && !prs_we))
		else $error("store written on a flagged request");

	a_found_row_open: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !none_q) |-> !(&(prs_rdata | pad_out)))
		else $error("selected block has no absent value");

endmodule
